[src/agf_pkg.sv]
package agf_pkg;

  // Shared multiplier operand and product widths (33 bits carries a 32-bit unsigned value)
  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 2 * MulW;

  // Variance limits in unsigned Q16.32
  localparam logic [47:0] VarFloor = 48'd4295;
  localparam logic [47:0] VarMax   = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MEAN_CONST = 3'd0,
    REG_AR_COEF    = 3'd1,
    REG_MA_COEF    = 3'd2,
    REG_OMEGA      = 3'd3,
    REG_ALPHA_COEF = 3'd4,
    REG_BETA_COEF  = 3'd5,
    REG_DIFF_ORDER = 3'd6
  } agf_reg_e;

endpackage

[src/agf_mul.sv]
module agf_mul (
  input  logic                                  clk_i,
  input  logic signed [agf_pkg::MulW-1:0]       a_i,
  input  logic signed [agf_pkg::MulW-1:0]       b_i,
  output logic signed [agf_pkg::ProdW-1:0]      p_o
);

  logic signed [agf_pkg::ProdW-1:0] p_d;
  logic signed [agf_pkg::ProdW-1:0] p_q;

  // Full signed product, registered
  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

[src/arma_garch_residual_variance_filter_unit.sv]
// Channel   Direction  Handshake                Beat contents
// in        sink       in_valid_i / in_stall_o   sample_i, series_start_i
// out       source     out_valid_o / out_stall_i diff_value_o, residual_o, variance_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample that only fills the difference history leaves the sequencer idle.
// A sample with lag terms keeps the input stalled until its result is handed over:
// eight products go one per cycle through a single registered 33x33 multiplier.
// The first result of a series skips the multiplier and goes straight to done.
// A finished result waits in the output register while out_stall_i is high;
// the next result is held in the sequencer until that register frees up.
// rst_ni clears history, sequencer and output valid, and loads register defaults.
module arma_garch_residual_variance_filter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] sample_i,
  input  logic               series_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] diff_value_o,
  output logic signed [31:0] residual_o,
  output logic        [47:0] variance_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [47:0] cfg_data_i
);

  localparam int unsigned MulW  = agf_pkg::MulW;
  localparam int unsigned ProdW = agf_pkg::ProdW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_SQ,   // e_prev * e_prev
    OP_AR,   // ar * y_prev
    OP_MA,   // ma * e_prev
    OP_BLO,  // h_prev[31:0] * beta
    OP_BHI,  // h_prev[47:32] * beta
    OP_ALO,  // e2[47:16] * alpha
    OP_AHI,  // e2[63:48] * alpha
    OP_AFR   // e2[15:0] * alpha
  } op_e;

  localparam logic [3:0] LastStep = 4'd8;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic signed [31:0] mean_q, ar_q, ma_q;
  logic        [47:0] omega_q;
  logic        [15:0] alpha_q, beta_q;
  logic        [1:0]  order_q;

  // Series history
  logic signed [31:0] raw0_q, raw1_q;
  logic signed [31:0] ydly_q, edly_q;
  logic        [47:0] hdly_q;
  logic        [1:0]  fill_q;

  // Sequencer and working registers
  state_e             state_q;
  logic        [3:0]  step_q;
  logic signed [31:0] x_q;
  logic signed [31:0] ys_q;
  logic               start_q;
  logic        [1:0]  cnt_q;
  logic signed [49:0] fit_q;
  logic        [63:0] e2_q;
  logic        [64:0] bacc_q;
  logic        [63:0] hacc_q;

  // Output register
  logic               out_valid_q;
  logic signed [31:0] out_y_q, out_e_q;
  logic        [47:0] out_h_q;

  // Accept-side signals
  logic               in_acc;
  logic        [1:0]  ord_eff;
  logic        [1:0]  cnt_in;
  logic               emit_in;
  logic               prev_in;
  logic signed [33:0] x34, r0_34, r1_34, y34;
  logic signed [31:0] ys_in;

  // Multiplier signals
  op_e                       launch_op, consume_op;
  logic               [3:0]  step_m1;
  logic signed [MulW-1:0]    mul_a, mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [ProdW-1:0]   prod_rnd;
  logic               [32:0] afr_sum;
  logic               [64:0] brnd_sum;

  // Finish signals
  logic signed [50:0] e51;
  logic signed [31:0] e_fin;
  logic        [47:0] h_fin;
  logic               load;
  logic        [1:0]  fill_next;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Difference the incoming sample and decide whether it gives a result
  always_comb begin
    ord_eff = (order_q == 2'd3) ? 2'd2 : order_q;
    cnt_in  = series_start_i ? 2'd0 : fill_q;
    emit_in = (cnt_in >= ord_eff);
    prev_in = ({1'b0, cnt_in} >= ({1'b0, ord_eff} + 3'd1));
    x34     = 34'(sample_i);
    r0_34   = 34'(raw0_q);
    r1_34   = 34'(raw1_q);
    case (ord_eff)
      2'd0:    y34 = x34;
      2'd1:    y34 = x34 - r0_34;
      default: y34 = x34 - (r0_34 <<< 1) + r1_34;
    endcase
    ys_in = sat32(51'(y34));
  end

  // Select multiplier operands for the step being launched
  assign launch_op  = op_e'(step_q[2:0]);
  assign step_m1    = step_q - 4'd1;
  assign consume_op = op_e'(step_m1[2:0]);

  always_comb begin
    unique case (launch_op)
      OP_SQ: begin
        mul_a = MulW'(edly_q);
        mul_b = MulW'(edly_q);
      end
      OP_AR: begin
        mul_a = MulW'(ar_q);
        mul_b = MulW'(ydly_q);
      end
      OP_MA: begin
        mul_a = MulW'(ma_q);
        mul_b = MulW'(edly_q);
      end
      OP_BLO: begin
        mul_a = $signed({1'b0, hdly_q[31:0]});
        mul_b = $signed({{(MulW-16){1'b0}}, beta_q});
      end
      OP_BHI: begin
        mul_a = $signed({{(MulW-16){1'b0}}, hdly_q[47:32]});
        mul_b = $signed({{(MulW-16){1'b0}}, beta_q});
      end
      OP_ALO: begin
        mul_a = $signed({1'b0, e2_q[47:16]});
        mul_b = $signed({{(MulW-16){1'b0}}, alpha_q});
      end
      OP_AHI: begin
        mul_a = $signed({{(MulW-16){1'b0}}, e2_q[63:48]});
        mul_b = $signed({{(MulW-16){1'b0}}, alpha_q});
      end
      OP_AFR: begin
        mul_a = $signed({{(MulW-16){1'b0}}, e2_q[15:0]});
        mul_b = $signed({{(MulW-16){1'b0}}, alpha_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  agf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Rounding of products: half up, floor shift by 16
  assign prod_rnd = (prod + ProdW'(32768)) >>> 16;
  assign afr_sum  = {1'b0, prod[31:0]} + 33'h0_0000_8000;
  assign brnd_sum = bacc_q + 65'h8000;

  // Finish: residual and variance with saturation and floor, next fill count, output load
  always_comb begin
    e51   = 51'(ys_q) - 51'(fit_q);
    e_fin = sat32(e51);
    if (hacc_q[63:48] != 16'd0) begin
      h_fin = agf_pkg::VarMax;
    end else if (hacc_q[47:0] < agf_pkg::VarFloor) begin
      h_fin = agf_pkg::VarFloor;
    end else begin
      h_fin = hacc_q[47:0];
    end
    fill_next = (cnt_q == 2'd3) ? 2'd3 : cnt_q + 2'd1;
    load      = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= '0;
      ar_q    <= 32'sd6554;
      ma_q    <= 32'sd6554;
      omega_q <= 48'd42949673;
      alpha_q <= 16'd6554;
      beta_q  <= 16'd52429;
      order_q <= 2'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        agf_pkg::REG_MEAN_CONST: mean_q  <= cfg_data_i[31:0];
        agf_pkg::REG_AR_COEF:    ar_q    <= cfg_data_i[31:0];
        agf_pkg::REG_MA_COEF:    ma_q    <= cfg_data_i[31:0];
        agf_pkg::REG_OMEGA:      omega_q <= cfg_data_i;
        agf_pkg::REG_ALPHA_COEF: alpha_q <= cfg_data_i[15:0];
        agf_pkg::REG_BETA_COEF:  beta_q  <= cfg_data_i[15:0];
        agf_pkg::REG_DIFF_ORDER: order_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, history and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_y_q     <= '0;
      out_e_q     <= '0;
      out_h_q     <= '0;
      raw0_q      <= '0;
      raw1_q      <= '0;
      ydly_q      <= '0;
      edly_q      <= '0;
      hdly_q      <= '0;
      fill_q      <= '0;
      x_q         <= '0;
      ys_q        <= '0;
      start_q     <= 1'b0;
      cnt_q       <= '0;
      fit_q       <= '0;
      e2_q        <= '0;
      bacc_q      <= '0;
      hacc_q      <= '0;
    end else begin
      // Raise valid on a new result beat, drop it once the old one is taken
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (series_start_i) begin
              ydly_q <= '0;
              edly_q <= '0;
              hdly_q <= '0;
            end
            if (!emit_in) begin
              // Fill the history only
              raw1_q <= series_start_i ? 32'sd0 : raw0_q;
              raw0_q <= sample_i;
              fill_q <= cnt_in + 2'd1;
            end else begin
              x_q     <= sample_i;
              ys_q    <= ys_in;
              start_q <= series_start_i;
              cnt_q   <= cnt_in;
              fit_q   <= 50'(mean_q);
              hacc_q  <= 64'(omega_q);
              bacc_q  <= '0;
              step_q  <= '0;
              state_q <= prev_in ? ST_CALC : ST_DONE;
            end
          end
        end

        ST_CALC: begin
          // Fold in the product launched last cycle
          if (step_q != 4'd0) begin
            unique case (consume_op)
              OP_SQ:  e2_q   <= prod[63:0];
              OP_AR:  fit_q  <= fit_q + prod_rnd[49:0];
              OP_MA:  fit_q  <= fit_q + prod_rnd[49:0];
              OP_BLO: bacc_q <= bacc_q + {1'b0, prod[63:0]};
              OP_BHI: bacc_q <= bacc_q + {1'b0, prod[31:0], 32'd0};
              OP_ALO: hacc_q <= hacc_q + prod[63:0];
              OP_AHI: hacc_q <= hacc_q + {prod[31:0], 32'd0};
              OP_AFR: hacc_q <= hacc_q + 64'(afr_sum[32:16]) + 64'(brnd_sum[64:16]);
              default: ;
            endcase
          end
          if (step_q == LastStep) begin
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end

        ST_DONE: begin
          // Hand the result over and advance the series history
          if (load) begin
            out_y_q     <= ys_q;
            out_e_q     <= e_fin;
            out_h_q     <= h_fin;
            raw1_q      <= start_q ? 32'sd0 : raw0_q;
            raw0_q      <= x_q;
            ydly_q      <= ys_q;
            edly_q      <= e_fin;
            hdly_q      <= h_fin;
            fill_q      <= fill_next;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign diff_value_o = out_y_q;
  assign residual_o   = out_e_q;
  assign variance_o   = out_h_q;

endmodule

[src/agf_checker.sv]
module agf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] diff_value_o,
  input logic signed [31:0] residual_o,
  input logic        [47:0] variance_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(diff_value_o) && $stable(residual_o) && $stable(variance_o))
    else $error("result beat changed while stalled");

  // Variance never drops below its floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> variance_o >= 48'd4295)
    else $error("variance below floor");

  // A new result appears only after the block was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without busy sequencer");

  // No result is ready in the cycle right after a sample is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result arrived too early");

endmodule

bind arma_garch_residual_variance_filter_unit agf_checker u_agf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .diff_value_o (diff_value_o),
  .residual_o   (residual_o),
  .variance_o   (variance_o)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam logic signed [31:0] MaxQ16 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinQ16 = 32'sh8000_0000;
  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned LongHold = 300;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseItems = 70;
  localparam int unsigned NumPhases = 10;

  // One result beat: differenced value, residual, variance
  typedef struct {
    logic signed [31:0] diff_value;
    logic signed [31:0] residual;
    logic        [47:0] variance;
  } fit_t;

  // Tracks the filter state, predicts each result and checks the output beats
  class arma_garch_scoreboard;
    logic signed [31:0] mean_c, ar_c, ma_c;
    logic        [47:0] omega_c;
    logic        [15:0] alpha_c, beta_c;
    logic        [1:0]  order_c;
    logic signed [31:0] hist0, hist1, prev_diff, prev_res;
    logic        [47:0] prev_var;
    int unsigned        filled;
    fit_t               fit_q[$];
    int unsigned        errors, accepted, results;

    function new();
      mean_c = '0;
      ar_c = 32'sd6554;
      ma_c = 32'sd6554;
      omega_c = 48'd42949673;
      alpha_c = 16'd6554;
      beta_c = 16'd52429;
      order_c = 2'd1;
      hist0 = '0;
      hist1 = '0;
      prev_diff = '0;
      prev_res = '0;
      prev_var = '0;
      filled = 0;
      errors = 0;
      accepted = 0;
      results = 0;
    endfunction

    function int unsigned pending();
      return fit_q.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] data);
      case (idx)
        agf_pkg::REG_MEAN_CONST: mean_c = data[31:0];
        agf_pkg::REG_AR_COEF:    ar_c = data[31:0];
        agf_pkg::REG_MA_COEF:    ma_c = data[31:0];
        agf_pkg::REG_OMEGA:      omega_c = data;
        agf_pkg::REG_ALPHA_COEF: alpha_c = data[15:0];
        agf_pkg::REG_BETA_COEF:  beta_c = data[15:0];
        agf_pkg::REG_DIFF_ORDER: order_c = data[1:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > SatHi) return MaxQ16;
      if (v < SatLo) return MinQ16;
      return v[31:0];
    endfunction

    // Round half up, then floor divide by 2^16
    function longint rnd16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function void predict_sample(logic signed [31:0] x, logic start_bit);
      int unsigned eff_order, cnt;
      longint      y, fitted;
      logic signed [31:0] ys, es;
      logic [63:0] sq, h;
      fit_t        r;
      accepted++;
      eff_order = (order_c > 2'd2) ? 2 : order_c;
      cnt = start_bit ? 0 : filled;
      // Clear history on a new series
      if (start_bit) begin
        hist0 = '0;
        hist1 = '0;
        prev_diff = '0;
        prev_res = '0;
        prev_var = '0;
      end
      // Still filling the difference history: store only
      if (cnt < eff_order) begin
        hist1 = hist0;
        hist0 = x;
        filled = cnt + 1;
        return;
      end
      case (eff_order)
        0: y = longint'(x);
        1: y = longint'(x) - longint'(hist0);
        default: y = longint'(x) - 2 * longint'(hist0) + longint'(hist1);
      endcase
      ys = clamp32(y);
      fitted = longint'(mean_c);
      h = 64'(omega_c);
      // Lag terms exist only past the first differenced value
      if (cnt >= eff_order + 1) begin
        fitted += rnd16(longint'(ar_c) * longint'(prev_diff));
        fitted += rnd16(longint'(ma_c) * longint'(prev_res));
        sq = 64'(longint'(prev_res) * longint'(prev_res));
        h += (sq >> 16) * 64'(alpha_c) + (((sq & 64'hFFFF) * 64'(alpha_c) + 64'h8000) >> 16);
        h += (64'(prev_var) * 64'(beta_c) + 64'h8000) >> 16;
      end
      es = clamp32(longint'(ys) - fitted);
      if (h > 64'(agf_pkg::VarMax)) h = 64'(agf_pkg::VarMax);
      if (h < 64'(agf_pkg::VarFloor)) h = 64'(agf_pkg::VarFloor);
      hist1 = hist0;
      hist0 = x;
      prev_diff = ys;
      prev_res = es;
      prev_var = h[47:0];
      filled = (cnt < 3) ? cnt + 1 : 3;
      r.diff_value = ys;
      r.residual = es;
      r.variance = h[47:0];
      fit_q.insert(fit_q.size(), r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic signed [31:0] y, logic signed [31:0] e, logic [47:0] h);
      fit_t want;
      if (fit_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: y=%0d e=%0d h=%0d", y, e, h));
        return;
      end
      want = fit_q.pop_front();
      results++;
      if (y !== want.diff_value)
        report_mismatch($sformatf("diff_value %0d, want %0d", y, want.diff_value));
      if (e !== want.residual)
        report_mismatch($sformatf("residual %0d, want %0d", e, want.residual));
      if (h !== want.variance)
        report_mismatch($sformatf("variance %0d, want %0d", h, want.variance));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] sample_i = '0;
  logic               series_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] diff_value_o;
  logic signed [31:0] residual_o;
  logic        [47:0] variance_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic        [2:0]  cfg_index_i = agf_pkg::REG_MEAN_CONST;
  logic        [47:0] cfg_data_i = '0;

  arma_garch_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  int unsigned cfg_writes = 0;
  int unsigned settings_used = 0;

  arma_garch_residual_variance_filter_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .series_start_i (series_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .diff_value_o   (diff_value_o),
    .residual_o     (residual_o),
    .variance_o     (variance_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver stall: random per cycle, or a long hold when requested
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check every result beat taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(diff_value_o, residual_o, variance_o);
  end

  // Offer one sample beat, idling first at random; returns at the next falling edge
  task automatic send_sample(input logic signed [31:0] x, input logic start_bit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= x;
    series_start_i <= start_bit;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.predict_sample(x, start_bit);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every pending result, then let in-flight work settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write all registers; unused upper data bits carry junk
  task automatic configure(input logic signed [31:0] mean, input logic signed [31:0] ar,
                           input logic signed [31:0] ma, input logic [47:0] om,
                           input logic [15:0] al, input logic [15:0] be,
                           input logic [1:0] ord);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(agf_pkg::REG_MEAN_CONST, {junk[15:0], mean});
    write_reg(agf_pkg::REG_AR_COEF, {junk[31:16], ar});
    write_reg(agf_pkg::REG_MA_COEF, {junk[47:32], ma});
    write_reg(agf_pkg::REG_OMEGA, om);
    write_reg(agf_pkg::REG_ALPHA_COEF, {junk[31:0], al});
    write_reg(agf_pkg::REG_BETA_COEF, {junk[63:32], be});
    write_reg(agf_pkg::REG_DIFF_ORDER, {junk[45:0], ord});
    settings_used++;
  endtask

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(7))
      0: return MinQ16;
      1: return MaxQ16;
      2: return $urandom;
      default: return int'($urandom_range(117964)) - 58982;
    endcase
  endfunction

  function automatic logic [47:0] rand_omega();
    case ($urandom_range(5))
      0: return '0;
      1: return agf_pkg::VarMax;
      2: return 48'({$urandom, $urandom});
      default: return 48'($urandom_range(67108864));
    endcase
  endfunction

  function automatic logic [15:0] rand_weight(input int unsigned typical_max);
    case ($urandom_range(5))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(typical_max));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(11))
      0: return MaxQ16;
      1: return MinQ16;
      2, 3: return $urandom;
      default: return int'($urandom_range(2097152)) - 1048576;
    endcase
  endfunction

  task automatic run_directed();
    // Reset settings, order one; first sample after reset starts a series
    send_sample(32'sd0, 1'b0);
    send_sample(MaxQ16, 1'b0);
    send_sample(MinQ16, 1'b0);
    send_sample(MaxQ16, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd327680, 1'b1);
    send_sample(32'sd458752, 1'b0);
    send_sample(32'sd196608, 1'b0);
    wait_idle();
    // Order zero with extreme coefficients: residual and variance saturate
    configure(MinQ16, MaxQ16, MinQ16, agf_pkg::VarMax, 16'hFFFF, 16'hFFFF, 2'd0);
    send_sample(MaxQ16, 1'b1);
    send_sample(MinQ16, 1'b0);
    send_sample(MaxQ16, 1'b0);
    send_sample(32'sd0, 1'b0);
    wait_idle();
    // Order three acts as two; the series goes on under the new order; zero weights hit the floor
    configure(MaxQ16, MinQ16, MaxQ16, 48'd0, 16'd0, 16'd0, 2'd3);
    send_sample(MinQ16, 1'b0);
    send_sample(MaxQ16, 1'b0);
    send_sample(MinQ16, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sd5, 1'b1);
    send_sample(32'sd6, 1'b0);
    send_sample(32'sd8, 1'b0);
    wait_idle();
    // Unknown index must leave every register alone
    write_reg(RegUnused, 48'({$urandom, $urandom}));
    configure(32'sd655, 32'sd32768, -32'sd19661, 48'd42949673, 16'd6554, 16'd52429, 2'd2);
    send_sample(32'sd65536, 1'b0);
    send_sample(-32'sd131072, 1'b0);
    send_sample(32'sd98304, 1'b0);
    send_sample(32'sd0, 1'b0);
    wait_idle();
  endtask

  task automatic run_random_phase(input int unsigned phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 65; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 65; end
      default: begin send_idle_pct = 21; stall_pct = 21; end
    endcase
    if ($urandom_range(3) == 0) write_reg(RegUnused, 48'({$urandom, $urandom}));
    configure(rand_q16(), rand_q16(), rand_q16(), rand_omega(), rand_weight(19661),
              rand_weight(58982), 2'($urandom_range(3)));
    // Mostly long series, with a new one started now and then
    for (int unsigned i = 0; i < PhaseItems; i++)
      send_sample(rand_sample(), $urandom_range(24) == 0);
    wait_idle();
  endtask

  // Hold the receiver off while samples keep coming, so the input stalls
  task automatic run_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    configure(32'sd0, 32'sd13107, 32'sd6554, 48'd42949673, 16'd6554, 16'd52429, 2'd1);
    hold_request = 1'b1;
    for (int unsigned i = 0; i < 30; i++)
      send_sample(rand_sample(), i == 0);
    wait_idle();
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (int unsigned p = 0; p < NumPhases; p++) run_random_phase(p);
    run_backpressure();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d samples over %0d register settings (orders 0-3, coefficient extremes,",
             sb.accepted, settings_used);
    $display("  sender gaps, receiver stalls, long hold); %0d results checked, %0d register writes",
             sb.results, cfg_writes);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out with %0d results pending", sb.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
